>>> rtl/core/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// shared types, constants and helpers of the console line to packet block
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

	localparam int LINE_CHARS = 255;
	localparam int CNT_W      = $clog2(LINE_CHARS + 1);
	localparam int QDEPTH     = 4;
	localparam int QA_W       = $clog2(QDEPTH);
	localparam int IN_W       = 40;
	localparam int OUT_W      = 128;

	localparam logic [2:0] ST_CMD      = 3'd0;
	localparam logic [2:0] ST_DISC     = 3'd1;
	localparam logic [2:0] ST_NO_SPEED = 3'd2;
	localparam logic [2:0] ST_BAD_MAC  = 3'd3;
	localparam logic [2:0] ST_NO_CLOSE = 3'd4;
	localparam logic [2:0] ST_NO_OPEN  = 3'd5;

	localparam logic [7:0] MAX_SPEED = 8'd100;
	localparam logic [7:0] MAX_SERVO = 8'd180;
	localparam logic [7:0] DEF_SERVO = 8'd90;
	localparam logic [3:0] DISC_LEN  = 4'd9;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN  = 8'h5b;
	localparam logic [7:0] CH_CLOSE = 8'h5d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_Q     = 8'h71;

	localparam logic [5:0] FL_FWD  = 6'h01;
	localparam logic [5:0] FL_BACK = 6'h02;
	localparam logic [5:0] FL_LEFT = 6'h04;
	localparam logic [5:0] FL_RGHT = 6'h08;
	localparam logic [5:0] FL_QL   = 6'h10;
	localparam logic [5:0] FL_QR   = 6'h20;

	typedef struct packed {
		logic [31:0] stamp;
		logic [7:0]  ch;
		logic        eol;
		logic        is_hex;
		logic [3:0]  hval;
		logic        is_dec;
		logic        is_ws;
	} tcl_item_t;

	// first member in the top bits, status lands in the lowest bits
	typedef struct packed {
		logic [7:0]  check_byte;
		logic [31:0] stamp;
		logic [7:0]  servo_b;
		logic [7:0]  servo_a;
		logic [6:0]  speed_pct;
		logic [5:0]  dir_flags;
		logic [7:0]  packet_type;
		logic [47:0] dest_mac;
		logic [2:0]  status;
	} tcl_result_t;

	function automatic logic [7:0] disc_char(input logic [3:0] i);
		logic [7:0] c;
		unique case (i)
			4'd0:    c = 8'h64;
			4'd1:    c = 8'h69;
			4'd2:    c = 8'h73;
			4'd3:    c = 8'h63;
			4'd4:    c = 8'h6f;
			4'd5:    c = 8'h76;
			4'd6:    c = 8'h65;
			4'd7:    c = 8'h72;
			4'd8:    c = 8'h79;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/tcl_front.sv
// ----------------------------------------------------------------------------
// tcl_front
// accepts console items and classifies each character for the parser
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_front (
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [tcl_pkg::IN_W-1:0] s_tdata,
	input  wire logic                     q_full,
	output logic                          q_push,
	output tcl_pkg::tcl_item_t            q_item
);
	import tcl_pkg::*;

	logic [7:0] c;

	assign c        = s_tdata[7:0];
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.stamp  = s_tdata[39:8];
		q_item.ch     = c;
		q_item.eol    = (c == CH_LF) || (c == CH_CR);
		q_item.is_dec = (c >= 8'h30) && (c <= 8'h39);
		q_item.is_ws  = (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
		q_item.is_hex = 1'b1;
		q_item.hval   = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			q_item.hval = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			q_item.hval = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			q_item.hval = 4'(c - 8'h37);
		end else begin
			q_item.is_hex = 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tcl_queue.sv
// ----------------------------------------------------------------------------
// tcl_queue
// short queue of classified items between front and parser
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tcl_pkg::tcl_item_t wdata,
	output logic                    full,
	output logic                    valid,
	output tcl_pkg::tcl_item_t      rdata,
	input  wire logic               pop
);
	import tcl_pkg::*;

	tcl_item_t         mem_q [QDEPTH];
	logic [QA_W-1:0]   wptr_q;
	logic [QA_W-1:0]   rptr_q;
	logic [QA_W:0]     cnt_q;

	assign full  = (cnt_q == (QA_W+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tcl_parse.sv
// ----------------------------------------------------------------------------
// tcl_parse
// per character line parser with result register
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_parse (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire tcl_pkg::tcl_item_t q_item,
	output logic                    q_pop,
	input  wire logic [7:0]         cmd_type,
	input  wire logic [7:0]         disc_type,
	output logic                    m_valid,
	input  wire logic               m_ready,
	output tcl_pkg::tcl_result_t    m_result
);
	import tcl_pkg::*;

	localparam logic [1:0] PH_PRE = 2'd0;
	localparam logic [1:0] PH_MAC = 2'd1;
	localparam logic [1:0] PH_DIR = 2'd2;
	localparam logic [1:0] PH_NUM = 2'd3;

	localparam logic [2:0] G_LEAD = 3'd0;
	localparam logic [2:0] G_SIGN = 3'd1;
	localparam logic [2:0] G_ZERO = 3'd2;
	localparam logic [2:0] G_ZX   = 3'd3;
	localparam logic [2:0] G_DIG  = 3'd4;
	localparam logic [2:0] G_DONE = 3'd5;

	localparam logic [1:0] N_LEAD = 2'd0;
	localparam logic [1:0] N_DIG  = 2'd1;
	localparam logic [1:0] N_DONE = 2'd2;

	logic [CNT_W-1:0] cnt_q, n_cnt;
	logic             frozen_q, n_frozen;
	logic             dok_q, n_dok;
	logic [3:0]       dpos_q, n_dpos;
	logic [1:0]       ph_q, n_ph;
	logic [2:0]       gst_q, n_gst;
	logic [2:0]       grp_q, n_grp;
	logic             gneg_q, n_gneg;
	logic [7:0]       gacc_q, n_gacc;
	logic             fail_q, n_fail;
	logic [47:0]      mac_q, n_mac;
	logic [5:0]       flags_q, n_flags;
	logic             qpend_q, n_qpend;
	logic [1:0]       fidx_q, n_fidx;
	logic [1:0]       nst_q, n_nst;
	logic             nneg_q, n_nneg;
	logic [7:0]       nacc_q, n_nacc;
	logic [7:0]       spd_q, n_spd;
	logic [7:0]       s1_q, n_s1;
	logic             m_valid_q;
	tcl_result_t      res_q;

	logic [7:0]       c;
	logic             act;
	logic             emits;
	logic [7:0]       lim;
	logic [7:0]       fv;
	logic [7:0]       gv;
	logic [10:0]      prod;
	logic [7:0]       spd_f, s1_f, s2_f;
	tcl_result_t      res;

	assign c       = q_item.ch;
	assign act     = (cnt_q != CNT_W'(LINE_CHARS)) && !frozen_q && (c != CH_NUL);
	assign emits   = q_item.eol && (cnt_q != '0);
	assign q_pop   = q_valid && (!emits || !m_valid_q || m_ready);
	assign lim     = (fidx_q == 2'd0) ? MAX_SPEED : MAX_SERVO;
	assign fv      = nneg_q ? 8'd0 : ((nacc_q > lim) ? lim : nacc_q);
	assign gv      = gneg_q ? (8'd0 - gacc_q) : gacc_q;
	assign prod    = ({3'b0, nacc_q} << 3) + ({3'b0, nacc_q} << 1) + {7'b0, q_item.hval};
	assign m_valid  = m_valid_q;
	assign m_result = res_q;

	// result of the line as it stands
	always_comb begin
		spd_f = (fidx_q == 2'd0) ? fv : spd_q;
		s1_f  = (fidx_q == 2'd0) ? DEF_SERVO : ((fidx_q == 2'd1) ? fv : s1_q);
		s2_f  = (fidx_q == 2'd2) ? fv : DEF_SERVO;
		res             = '0;
		res.stamp       = q_item.stamp;
		if (dok_q && dpos_q == DISC_LEN) begin
			res.status      = ST_DISC;
			res.dest_mac    = '1;
			res.packet_type = disc_type;
			res.servo_a     = DEF_SERVO;
			res.servo_b     = DEF_SERVO;
			res.check_byte  = disc_type ^ q_item.stamp[7:0];
		end else begin
			unique case (ph_q)
				PH_PRE: res.status = ST_NO_OPEN;
				PH_MAC: res.status = ST_NO_CLOSE;
				PH_DIR: begin
					res.status = fail_q ? ST_BAD_MAC : ST_NO_SPEED;
					if (!fail_q) begin
						res.dest_mac = mac_q;
					end
				end
				default: begin
					if (fail_q) begin
						res.status = ST_BAD_MAC;
					end else begin
						res.status      = ST_CMD;
						res.dest_mac    = mac_q;
						res.packet_type = cmd_type;
						res.dir_flags   = flags_q;
						res.speed_pct   = spd_f[6:0];
						res.servo_a     = s1_f;
						res.servo_b     = s2_f;
						res.check_byte  = cmd_type ^ {2'b0, flags_q} ^ spd_f ^ s1_f ^ s2_f
							^ q_item.stamp[7:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		n_cnt = cnt_q;     n_frozen = frozen_q; n_dok = dok_q;   n_dpos = dpos_q;
		n_ph = ph_q;       n_gst = gst_q;       n_grp = grp_q;   n_gneg = gneg_q;
		n_gacc = gacc_q;   n_fail = fail_q;     n_mac = mac_q;   n_flags = flags_q;
		n_qpend = qpend_q; n_fidx = fidx_q;     n_nst = nst_q;   n_nneg = nneg_q;
		n_nacc = nacc_q;   n_spd = spd_q;       n_s1 = s1_q;
		if (q_pop) begin
			if (q_item.eol) begin
				n_cnt = '0;   n_frozen = 1'b0; n_dok = 1'b1; n_dpos = '0;
				n_ph = PH_PRE; n_fail = 1'b0;  n_mac = '0;   n_flags = '0;
				n_qpend = 1'b0;
			end else begin
				if (cnt_q != CNT_W'(LINE_CHARS)) begin
					n_cnt = cnt_q + 1'b1;
					if (c == CH_NUL) begin
						n_frozen = 1'b1;
					end
				end
				if (act) begin
					if (dok_q && dpos_q < DISC_LEN && c == disc_char(dpos_q)) begin
						n_dpos = dpos_q + 1'b1;
					end else begin
						n_dok = 1'b0;
					end
					unique case (ph_q)
						PH_PRE: begin
							if (c == CH_OPEN) begin
								n_ph = PH_MAC; n_gst = G_LEAD; n_grp = '0;
								n_gneg = 1'b0; n_gacc = '0;
							end
						end
						PH_MAC: begin
							if (c == CH_CLOSE) begin
								n_ph = PH_DIR;
								if (gst_q == G_DONE) begin
									n_fail = fail_q;
								end else if ((gst_q == G_ZERO || gst_q == G_DIG)
									&& grp_q == 3'd5) begin
									n_mac = {mac_q[39:0], gv};
								end else begin
									n_fail = 1'b1;
								end
							end else begin
								unique case (gst_q)
									G_LEAD: begin
										if (q_item.is_ws) begin
											n_gst = G_LEAD;
										end else if (c == CH_PLUS || c == CH_MINUS) begin
											n_gst = G_SIGN; n_gneg = (c == CH_MINUS);
										end else if (c == CH_ZERO) begin
											n_gst = G_ZERO; n_gacc = '0;
										end else if (q_item.is_hex) begin
											n_gst = G_DIG; n_gacc = {4'b0, q_item.hval};
										end else begin
											n_fail = 1'b1; n_gst = G_DONE;
										end
									end
									G_SIGN: begin
										if (c == CH_ZERO) begin
											n_gst = G_ZERO; n_gacc = '0;
										end else if (q_item.is_hex) begin
											n_gst = G_DIG; n_gacc = {4'b0, q_item.hval};
										end else begin
											n_fail = 1'b1; n_gst = G_DONE;
										end
									end
									G_ZX: begin
										if (q_item.is_hex) begin
											n_gst = G_DIG; n_gacc = {4'b0, q_item.hval};
										end else begin
											n_fail = 1'b1; n_gst = G_DONE;
										end
									end
									G_ZERO, G_DIG: begin
										if (gst_q == G_ZERO && (c == CH_LX || c == CH_UX)) begin
											n_gst = G_ZX;
										end else if (q_item.is_hex) begin
											n_gst = G_DIG; n_gacc = {gacc_q[3:0], q_item.hval};
										end else begin
											n_mac = {mac_q[39:0], gv};
											if (grp_q == 3'd5) begin
												n_gst = G_DONE;
											end else if (c == CH_COLON) begin
												n_grp = grp_q + 1'b1; n_gst = G_LEAD;
												n_gneg = 1'b0; n_gacc = '0;
											end else begin
												n_fail = 1'b1; n_gst = G_DONE;
											end
										end
									end
									default: n_gst = G_DONE;
								endcase
							end
						end
						PH_DIR: begin
							if (c == CH_SPACE) begin
								n_ph = PH_NUM; n_fidx = '0; n_nst = N_LEAD;
								n_nneg = 1'b0; n_nacc = '0;
							end else if (qpend_q) begin
								n_qpend = 1'b0;
								if (c == CH_L) begin
									n_flags = flags_q | FL_QL;
								end else if (c == CH_R) begin
									n_flags = flags_q | FL_QR;
								end
							end else begin
								priority case (c)
									CH_Q: n_qpend = 1'b1;
									CH_F: n_flags = flags_q | FL_FWD;
									CH_B: n_flags = flags_q | FL_BACK;
									CH_L: n_flags = flags_q | FL_LEFT;
									CH_R: n_flags = flags_q | FL_RGHT;
									default: n_flags = flags_q;
								endcase
							end
						end
						default: begin
							if (c == CH_SPACE && fidx_q != 2'd2) begin
								if (fidx_q == 2'd0) begin
									n_spd = fv;
								end else begin
									n_s1 = fv;
								end
								n_fidx = fidx_q + 1'b1; n_nst = N_LEAD;
								n_nneg = 1'b0; n_nacc = '0;
							end else begin
								unique case (nst_q)
									N_LEAD: begin
										if (q_item.is_ws) begin
											n_nst = N_LEAD;
										end else if (c == CH_PLUS || c == CH_MINUS) begin
											n_nst = N_DIG; n_nneg = (c == CH_MINUS);
										end else if (q_item.is_dec) begin
											n_nst = N_DIG; n_nacc = {4'b0, q_item.hval};
										end else begin
											n_nst = N_DONE;
										end
									end
									N_DIG: begin
										if (q_item.is_dec) begin
											n_nacc = (prod > {3'b0, lim}) ? (lim + 8'd1) : prod[7:0];
										end else begin
											n_nst = N_DONE;
										end
									end
									default: n_nst = N_DONE;
								endcase
							end
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;   frozen_q <= 1'b0; dok_q <= 1'b1;  dpos_q <= '0;
			ph_q <= PH_PRE; gst_q <= G_LEAD; grp_q <= '0;   gneg_q <= 1'b0;
			gacc_q <= '0;  fail_q <= 1'b0;   mac_q <= '0;   flags_q <= '0;
			qpend_q <= 1'b0; fidx_q <= '0;   nst_q <= N_LEAD; nneg_q <= 1'b0;
			nacc_q <= '0;  spd_q <= '0;      s1_q <= '0;    m_valid_q <= 1'b0;
		end else begin
			cnt_q <= n_cnt;     frozen_q <= n_frozen; dok_q <= n_dok;   dpos_q <= n_dpos;
			ph_q <= n_ph;       gst_q <= n_gst;       grp_q <= n_grp;   gneg_q <= n_gneg;
			gacc_q <= n_gacc;   fail_q <= n_fail;     mac_q <= n_mac;   flags_q <= n_flags;
			qpend_q <= n_qpend; fidx_q <= n_fidx;     nst_q <= n_nst;   nneg_q <= n_nneg;
			nacc_q <= n_nacc;   spd_q <= n_spd;       s1_q <= n_s1;
			if (q_pop && emits) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emits) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/text_command_line_to_packet.sv
// ----------------------------------------------------------------------------
// text_command_line_to_packet
// console characters in, one command, discovery or error item per non-empty line out
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit first)
//  s_axis    in   rx_byte[7:0], now_ms[39:8]
//  m_axis    out  status, dest_mac, packet_type, dir_flags, speed_pct,
//                 servo_a, servo_b, stamp, check_byte (128 bits)
//  apb       cfg  0x0 command_type_code, 0x4 discovery_type_code
//
// one character item per cycle unless the queue is full; the parser pops one item
// per cycle unless a result waits; line ends reach m_tvalid via queue, then result
// reset clears the line state, queue and result valid; type codes go to 0 and 1
// the four-entry queue keeps input flowing while a result waits on m_tready
// ----------------------------------------------------------------------------
`default_nettype none

module text_command_line_to_packet (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [tcl_pkg::IN_W-1:0]  s_tdata,  // rx_byte, now_ms
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [tcl_pkg::OUT_W-1:0]      m_tdata,  // status, dest_mac, packet_type,
	                                                 // dir_flags, speed_pct, servo_a,
	                                                 // servo_b, stamp, check_byte
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import tcl_pkg::*;

	logic        q_full;
	logic        q_push;
	logic        q_valid;
	logic        q_pop;
	tcl_item_t   w_item;
	tcl_item_t   r_item;
	tcl_result_t result;
	logic [7:0]  cmd_type_q;
	logic [7:0]  disc_type_q;
	logic [7:0]  rd_val;

	assign pready  = 1'b1;
	assign rd_val  = paddr[2] ? disc_type_q : cmd_type_q;
	assign prdata  = (paddr[1:0] == 2'b00) ? {24'b0, rd_val} : 32'b0;
	assign m_tdata = result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_type_q  <= 8'd0;
			disc_type_q <= 8'd1;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				disc_type_q <= pwdata[7:0];
			end else begin
				cmd_type_q <= pwdata[7:0];
			end
		end
	end

	tcl_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (w_item)
	);

	tcl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (w_item),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (r_item),
		.pop    (q_pop)
	);

	tcl_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (r_item),
		.q_pop     (q_pop),
		.cmd_type  (cmd_type_q),
		.disc_type (disc_type_q),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_result  (result)
	);

endmodule

`default_nettype wire
